/* hw/rtl/moi_pkg.sv */
// Shared types, constants and helper functions for the mecanum odometry integrator.
// Used by every module of the block; depends on nothing else.
package moi_pkg;

	localparam int STAMP_WIDTH   = 32;
	localparam int SINE_BITS_DEF = 16;
	localparam int CORDIC_STEPS  = 30;
	localparam int CORDIC_FRAC   = 30;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 8'd2;

	localparam logic [15:0] GAIN_RST   = 16'd16384;
	localparam logic [19:0] RADIUS_RST = 20'd45000;

	localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
	// The position scale 2000000 is 2^7 * 15625. The power of two is shifted out and
	// the odd part is divided by a reciprocal estimate with a small correction.
	localparam logic [13:0] DIV_ODD   = 14'd15625;
	localparam logic [26:0] DIV_RECIP = 27'd70368744;
	localparam logic signed [63:0] POS_HALF = 64'sd1000000;
	localparam logic signed [63:0] ACC_MAX  = 64'sd1099511627774000000;
	localparam logic signed [63:0] ACC_MIN  = -64'sd1099511627776000000;

	typedef struct packed {
		logic signed [15:0] wheel_speed_1;
		logic signed [15:0] wheel_speed_2;
		logic signed [15:0] wheel_speed_3;
		logic signed [15:0] wheel_speed_4;
		logic [15:0]        yaw_angle;
		logic [31:0]        stamp_us;
	} sample_t;

	typedef struct packed {
		logic signed [39:0] position_x;
		logic signed [39:0] position_y;
		logic signed [23:0] body_vel_x;
		logic signed [23:0] body_vel_y;
	} result_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		logic signed [17:0]     sx;
		logic signed [17:0]     sy;
		logic [15:0]            yaw;
		logic [STAMP_WIDTH-1:0] dt;
		logic                   first;
	} cmd_t;

	typedef struct packed {
		logic [15:0] gain_x;
		logic [15:0] gain_y;
		logic [19:0] radius;
	} cfg_t;

	typedef enum logic [4:0] {
		B_IDLE, B_VMUL, B_VRND, B_CORDIC, B_QUAD, B_WMUL, B_WSUM, B_WRND,
		B_VSUM, B_INC, B_ACC, B_CLAMP, B_MAG, B_DEST, B_DBACK, B_DFIX, B_OUT
	} back_state_t;

	function automatic logic signed [32:0] atan_val(input logic [4:0] i);
		logic signed [32:0] v;
		case (i)
			5'd0: v = 33'sh020000000;
			5'd1: v = 33'sh012E4051E;
			5'd2: v = 33'sh009FB385B;
			5'd3: v = 33'sh0051111D4;
			5'd4: v = 33'sh0028B0D43;
			5'd5: v = 33'sh00145D7E1;
			5'd6: v = 33'sh000A2F61E;
			5'd7: v = 33'sh000517C55;
			5'd8: v = 33'sh00028BE53;
			5'd9: v = 33'sh000145F2F;
			5'd10: v = 33'sh0000A2F98;
			5'd11: v = 33'sh0000517CC;
			5'd12: v = 33'sh000028BE6;
			5'd13: v = 33'sh0000145F3;
			5'd14: v = 33'sh00000A2FA;
			5'd15: v = 33'sh00000517D;
			5'd16: v = 33'sh0000028BE;
			5'd17: v = 33'sh00000145F;
			5'd18: v = 33'sh000000A30;
			5'd19: v = 33'sh000000518;
			5'd20: v = 33'sh00000028C;
			5'd21: v = 33'sh000000146;
			5'd22: v = 33'sh0000000A3;
			5'd23: v = 33'sh000000051;
			5'd24: v = 33'sh000000029;
			5'd25: v = 33'sh000000014;
			5'd26: v = 33'sh00000000A;
			5'd27: v = 33'sh000000005;
			5'd28: v = 33'sh000000003;
			5'd29: v = 33'sh000000001;
			default: v = 33'sh000000000;
		endcase
		return v;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		logic signed [23:0] r;
		if (v > 64'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/moi_queue.sv */
// Two-entry queue that holds classified items between the front and the back.
// Depends on moi_pkg for the item type and depth.
module moi_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  moi_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output moi_pkg::cmd_t rdata,
	output logic          empty
);
	moi_pkg::cmd_t mem_q [moi_pkg::QUEUE_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full  = (count_q == 2'(moi_pkg::QUEUE_DEPTH));
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end
endmodule

/* hw/rtl/moi_front.sv */
// Front end: takes samples, forms the wheel sums and the timestamp difference.
// Depends on moi_pkg for the sample and item types.
module moi_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  moi_pkg::sample_t sample,
	input  logic             q_full,
	output logic             q_wr,
	output moi_pkg::cmd_t    cmd
);
	logic                            seen_q;
	logic [moi_pkg::STAMP_WIDTH-1:0] last_stamp_q;
	logic signed [17:0] w1, w2, w3, w4;

	assign w1 = {{2{sample.wheel_speed_1[15]}}, sample.wheel_speed_1};
	assign w2 = {{2{sample.wheel_speed_2[15]}}, sample.wheel_speed_2};
	assign w3 = {{2{sample.wheel_speed_3[15]}}, sample.wheel_speed_3};
	assign w4 = {{2{sample.wheel_speed_4[15]}}, sample.wheel_speed_4};

	assign q_wr = push && !q_full;

	always_comb begin
		cmd.sx    = w1 + w2 + w3 + w4;
		cmd.sy    = w1 + w3 - w2 - w4;
		cmd.yaw   = sample.yaw_angle;
		// The first item integrates over zero time.
		cmd.dt    = seen_q ? (sample.stamp_us - last_stamp_q) : '0;
		cmd.first = !seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_stamp_q <= '0;
		end else if (q_wr) begin
			seen_q       <= 1'b1;
			last_stamp_q <= sample.stamp_us;
		end
	end
endmodule

/* hw/rtl/moi_back.sv */
// Back end: velocity scaling, CORDIC rotation, trapezoid integration and the
// position divider, all on one shared multiplier. Depends on moi_pkg.
module moi_back #(
	parameter int SINE_BITS = moi_pkg::SINE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  moi_pkg::cfg_t    cfg,
	input  logic             q_empty,
	input  moi_pkg::cmd_t    q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output moi_pkg::result_t result
);
	localparam int SH = moi_pkg::CORDIC_FRAC - SINE_BITS;
	localparam int CW = SINE_BITS + 2;
	localparam int TW = 24 + CW;

	moi_pkg::back_state_t state_q, state_d;
	logic [5:0]           cnt_q;
	logic                 res_load;
	moi_pkg::cmd_t        cmd_q;

	logic [35:0]          rgx_q, rgy_q;
	logic signed [54:0]   pvx_q, pvy_q;
	logic signed [23:0]   vx_q, vy_q;
	logic signed [32:0]   cx_q, cy_q, cz_q;
	logic signed [CW-1:0] c_q, s_q;
	logic signed [TW-1:0] t0_q, t1_q, t2_q, t3_q;
	logic signed [TW:0]   sumx_q, sumy_q;
	logic signed [23:0]   wx_q, wy_q, lvx_q, lvy_q;
	logic signed [24:0]   vsx_q, vsy_q;
	logic signed [57:0]   incx_q, incy_q;
	logic signed [63:0]   accx_q, accy_q, nsx_q, nsy_q;
	logic                 negx_q, negy_q;
	logic [1:0]           pass_q;
	logic [40:0]          part_q, bp_q, quox_q, quoy_q;
	logic [27:0]          qe_q;
	logic [13:0]          qhi_q;
	logic [26:0]          hiy_q, lox_q, loy_q;
	logic                 res_v_q;
	moi_pkg::result_t     res_q;

	logic signed [36:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [69:0] prod;

	logic signed [32:0] dx, dy, atn, cxm, sym, crnd, srnd;
	logic signed [63:0] magx, magy;
	logic [40:0]        dvsr, drem, dr;
	logic [27:0]        dq;
	logic signed [40:0] qx, qy;

	assign prod = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			moi_pkg::B_VMUL: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = {17'b0, cfg.radius};
						mul_b = {17'b0, cfg.gain_x};
					end
					2'd1: begin
						mul_a = {17'b0, cfg.radius};
						mul_b = {17'b0, cfg.gain_y};
					end
					2'd2: begin
						mul_a = {1'b0, rgx_q};
						mul_b = {{15{cmd_q.sx[17]}}, cmd_q.sx};
					end
					default: begin
						mul_a = {1'b0, rgy_q};
						mul_b = {{15{cmd_q.sy[17]}}, cmd_q.sy};
					end
				endcase
			end
			moi_pkg::B_WMUL: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = {{13{vx_q[23]}}, vx_q};
						mul_b = {{(33-CW){c_q[CW-1]}}, c_q};
					end
					2'd1: begin
						mul_a = {{13{vy_q[23]}}, vy_q};
						mul_b = {{(33-CW){s_q[CW-1]}}, s_q};
					end
					2'd2: begin
						mul_a = {{13{vx_q[23]}}, vx_q};
						mul_b = {{(33-CW){s_q[CW-1]}}, s_q};
					end
					default: begin
						mul_a = {{13{vy_q[23]}}, vy_q};
						mul_b = {{(33-CW){c_q[CW-1]}}, c_q};
					end
				endcase
			end
			moi_pkg::B_INC: begin
				mul_a = cnt_q[0] ? {{12{vsy_q[24]}}, vsy_q} : {{12{vsx_q[24]}}, vsx_q};
				mul_b = {1'b0, cmd_q.dt};
			end
			moi_pkg::B_DEST: begin
				mul_a = {10'b0, part_q[40:14]};
				mul_b = {6'b0, moi_pkg::DIV_RECIP};
			end
			moi_pkg::B_DBACK: begin
				mul_a = {9'b0, qe_q};
				mul_b = {19'b0, moi_pkg::DIV_ODD};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// CORDIC step, the quadrant fold and the quotient digit correction.
	always_comb begin
		dx   = cy_q >>> cnt_q[4:0];
		dy   = cx_q >>> cnt_q[4:0];
		atn  = moi_pkg::atan_val(cnt_q[4:0]);
		case (cmd_q.yaw[15:14])
			2'd0: begin
				cxm = cx_q;
				sym = cy_q;
			end
			2'd1: begin
				cxm = -cy_q;
				sym = cx_q;
			end
			2'd2: begin
				cxm = -cx_q;
				sym = -cy_q;
			end
			default: begin
				cxm = cy_q;
				sym = -cx_q;
			end
		endcase
		crnd = (cxm + (33'sd1 <<< (SH - 1))) >>> SH;
		srnd = (sym + (33'sd1 <<< (SH - 1))) >>> SH;
		magx = accx_q[63] ? (moi_pkg::POS_HALF - accx_q) : (accx_q + moi_pkg::POS_HALF);
		magy = accy_q[63] ? (moi_pkg::POS_HALF - accy_q) : (accy_q + moi_pkg::POS_HALF);
		// The reciprocal estimate is low by at most two, so two compares finish the digit.
		dvsr = {27'b0, moi_pkg::DIV_ODD};
		drem = part_q - bp_q;
		if (drem >= {dvsr[39:0], 1'b0}) begin
			dq = qe_q + 28'd2;
			dr = drem - {dvsr[39:0], 1'b0};
		end else if (drem >= dvsr) begin
			dq = qe_q + 28'd1;
			dr = drem - dvsr;
		end else begin
			dq = qe_q;
			dr = drem;
		end
		qx = negx_q ? -$signed(quox_q) : $signed(quox_q);
		qy = negy_q ? -$signed(quoy_q) : $signed(quoy_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			moi_pkg::B_IDLE:   if (!q_empty) state_d = moi_pkg::B_VMUL;
			moi_pkg::B_VMUL:   if (cnt_q == 6'd3) state_d = moi_pkg::B_VRND;
			moi_pkg::B_VRND:   state_d = moi_pkg::B_CORDIC;
			moi_pkg::B_CORDIC: begin
				if (cnt_q == 6'(moi_pkg::CORDIC_STEPS - 1)) state_d = moi_pkg::B_QUAD;
			end
			moi_pkg::B_QUAD:   state_d = moi_pkg::B_WMUL;
			moi_pkg::B_WMUL:   if (cnt_q == 6'd3) state_d = moi_pkg::B_WSUM;
			moi_pkg::B_WSUM:   state_d = moi_pkg::B_WRND;
			moi_pkg::B_WRND:   state_d = moi_pkg::B_VSUM;
			moi_pkg::B_VSUM:   state_d = moi_pkg::B_INC;
			moi_pkg::B_INC:    if (cnt_q == 6'd1) state_d = moi_pkg::B_ACC;
			moi_pkg::B_ACC:    state_d = moi_pkg::B_CLAMP;
			moi_pkg::B_CLAMP:  state_d = moi_pkg::B_MAG;
			moi_pkg::B_MAG:    state_d = moi_pkg::B_DEST;
			moi_pkg::B_DEST:   state_d = moi_pkg::B_DBACK;
			moi_pkg::B_DBACK:  state_d = moi_pkg::B_DFIX;
			moi_pkg::B_DFIX: begin
				state_d = (pass_q == 2'd3) ? moi_pkg::B_OUT : moi_pkg::B_DEST;
			end
			moi_pkg::B_OUT:    if (!res_v_q || pop) state_d = moi_pkg::B_IDLE;
			default:           state_d = moi_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_rd     = 1'b0;
		res_load = 1'b0;
		case (state_q)
			moi_pkg::B_IDLE: q_rd = !q_empty;
			moi_pkg::B_OUT:  res_load = !res_v_q || pop;
			default: begin
				q_rd     = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	assign empty  = !res_v_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= moi_pkg::B_IDLE;
			cnt_q   <= '0;
			res_v_q <= 1'b0;
			lvx_q   <= '0;
			lvy_q   <= '0;
			accx_q  <= '0;
			accy_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 6'd0 : cnt_q + 6'd1;
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
			if (state_q == moi_pkg::B_CLAMP) begin
				accx_q <= (nsx_q > moi_pkg::ACC_MAX) ? moi_pkg::ACC_MAX :
					(nsx_q < moi_pkg::ACC_MIN) ? moi_pkg::ACC_MIN : nsx_q;
				accy_q <= (nsy_q > moi_pkg::ACC_MAX) ? moi_pkg::ACC_MAX :
					(nsy_q < moi_pkg::ACC_MIN) ? moi_pkg::ACC_MIN : nsy_q;
				lvx_q  <= wx_q;
				lvy_q  <= wy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			moi_pkg::B_IDLE: begin
				cmd_q <= q_data;
			end
			moi_pkg::B_VMUL: begin
				case (cnt_q[1:0])
					2'd0: rgx_q <= prod[35:0];
					2'd1: rgy_q <= prod[35:0];
					2'd2: pvx_q <= prod[54:0];
					default: pvy_q <= prod[54:0];
				endcase
			end
			moi_pkg::B_VRND: begin
				vx_q <= moi_pkg::sat24(64'((pvx_q + 55'sd8388608) >>> 24));
				vy_q <= moi_pkg::sat24(64'((pvy_q + 55'sd8388608) >>> 24));
				cx_q <= moi_pkg::CORDIC_START;
				cy_q <= '0;
				cz_q <= {3'b0, cmd_q.yaw[13:0], 16'b0};
			end
			moi_pkg::B_CORDIC: begin
				if (!cz_q[32]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - atn;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + atn;
				end
			end
			moi_pkg::B_QUAD: begin
				c_q <= crnd[CW-1:0];
				s_q <= srnd[CW-1:0];
			end
			moi_pkg::B_WMUL: begin
				case (cnt_q[1:0])
					2'd0: t0_q <= prod[TW-1:0];
					2'd1: t1_q <= prod[TW-1:0];
					2'd2: t2_q <= prod[TW-1:0];
					default: t3_q <= prod[TW-1:0];
				endcase
			end
			moi_pkg::B_WSUM: begin
				sumx_q <= {t0_q[TW-1], t0_q} - {t1_q[TW-1], t1_q};
				sumy_q <= {t2_q[TW-1], t2_q} + {t3_q[TW-1], t3_q};
			end
			moi_pkg::B_WRND: begin
				wx_q <= moi_pkg::sat24(64'((sumx_q + ((TW+1)'(1) <<< (SINE_BITS - 1)))
					>>> SINE_BITS));
				wy_q <= moi_pkg::sat24(64'((sumy_q + ((TW+1)'(1) <<< (SINE_BITS - 1)))
					>>> SINE_BITS));
			end
			moi_pkg::B_VSUM: begin
				// On the first item the previous velocity is taken as the current one.
				vsx_q <= {wx_q[23], wx_q} + (cmd_q.first ? {wx_q[23], wx_q} : {lvx_q[23], lvx_q});
				vsy_q <= {wy_q[23], wy_q} + (cmd_q.first ? {wy_q[23], wy_q} : {lvy_q[23], lvy_q});
			end
			moi_pkg::B_INC: begin
				if (cnt_q[0]) begin
					incy_q <= prod[57:0];
				end else begin
					incx_q <= prod[57:0];
				end
			end
			moi_pkg::B_ACC: begin
				nsx_q <= accx_q + {{6{incx_q[57]}}, incx_q};
				nsy_q <= accy_q + {{6{incy_q[57]}}, incy_q};
			end
			moi_pkg::B_MAG: begin
				// Each magnitude is shifted right by 7 and split into two 27-bit digits.
				negx_q <= accx_q[63];
				negy_q <= accy_q[63];
				pass_q <= 2'd0;
				part_q <= {14'b0, magx[60:34]};
				lox_q  <= magx[33:7];
				hiy_q  <= magy[60:34];
				loy_q  <= magy[33:7];
			end
			moi_pkg::B_DEST: begin
				qe_q <= prod[53:26];
			end
			moi_pkg::B_DBACK: begin
				bp_q <= prod[40:0];
			end
			moi_pkg::B_DFIX: begin
				pass_q <= pass_q + 2'd1;
				case (pass_q)
					2'd0: begin
						qhi_q  <= dq[13:0];
						part_q <= {dr[13:0], lox_q};
					end
					2'd1: begin
						quox_q <= {qhi_q, dq[26:0]};
						part_q <= {14'b0, hiy_q};
					end
					2'd2: begin
						qhi_q  <= dq[13:0];
						part_q <= {dr[13:0], loy_q};
					end
					default: begin
						quoy_q <= {qhi_q, dq[26:0]};
					end
				endcase
			end
			moi_pkg::B_OUT: begin
				if (res_load) begin
					res_q.position_x <= qx[39:0];
					res_q.position_y <= qy[39:0];
					res_q.body_vel_x <= vx_q;
					res_q.body_vel_y <= vy_q;
				end
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end
endmodule

/* hw/rtl/mecanum_odometry_integrator.sv */
// From push to result an item passes the idle step, the velocity products, rounding,
// the CORDIC steps, the quadrant fold, rotation, integration, the magnitude step and
// the position divider, and the result load once the result register is free.
// The back end takes a new item only when done with the last; two items queue in front.
// Reset clears position, velocity history and the first-sample flag, and loads
// the gain and radius registers with their defaults.
module mecanum_odometry_integrator #(
	parameter int SINE_BITS = moi_pkg::SINE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  moi_pkg::sample_t                 sample,
	output logic                             empty,
	input  logic                             pop,
	output moi_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [moi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [moi_pkg::CFG_DATA_W-1:0]   cfg_data
);
	moi_pkg::cfg_t cfg_q;
	moi_pkg::cmd_t wr_cmd, rd_cmd;
	logic          q_wr, q_rd, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_x <= moi_pkg::GAIN_RST;
			cfg_q.gain_y <= moi_pkg::GAIN_RST;
			cfg_q.radius <= moi_pkg::RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				moi_pkg::CFG_GAIN_X: cfg_q.gain_x <= cfg_data[15:0];
				moi_pkg::CFG_GAIN_Y: cfg_q.gain_y <= cfg_data[15:0];
				moi_pkg::CFG_RADIUS: cfg_q.radius <= cfg_data[19:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	moi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sample (sample),
		.q_full (full),
		.q_wr   (q_wr),
		.cmd    (wr_cmd)
	);

	moi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (wr_cmd),
		.full   (full),
		.rd     (q_rd),
		.rdata  (rd_cmd),
		.empty  (q_empty)
	);

	moi_back #(
		.SINE_BITS (SINE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (rd_cmd),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);
endmodule

/* hw/rtl/moi_checker.sv */
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on moi_pkg for the result type.
module moi_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input moi_pkg::result_t result
);
	logic [2:0] open_q;

	// Items accepted whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 3'd0;
		end else begin
			open_q <= open_q + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
		end
	end

	a_no_result_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> open_q != 3'd0)
		else $error("result offered with no item outstanding");

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == 3'd4 |-> full)
		else $error("more items accepted than the block can hold");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");
endmodule

bind mecanum_odometry_integrator moi_checker u_moi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

/* test/mecanum_odometry_integrator_checker.sv */
// Checker for the mecanum odometry integrator: watches the sample, result and
// register write channels, predicts every result and compares it with the whole result.
// Depends on moi_pkg for the item structs and the register indexes.
`timescale 1ns / 100ps
module mecanum_odometry_integrator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  moi_pkg::sample_t               sample,
	input  logic                           empty,
	input  logic                           pop,
	input  moi_pkg::result_t               result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [moi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [moi_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import moi_pkg::*;

	localparam int SINE_W = 16;
	localparam longint ROT_X0 = 64'sd652032874;
	localparam longint ACC_HI = 64'sd549755813887 * 64'sd2000000;
	localparam longint ACC_LO = -64'sd549755813888 * 64'sd2000000;
	localparam longint INC_CAP = 64'sd1 <<< 62;
	localparam longint ANGLE_STEP [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

	logic [15:0] gx, gy;
	logic [19:0] radius;
	bit          started;
	logic [31:0] prev_stamp;
	longint      prev_wx, prev_wy, dist_x, dist_y;
	result_t     odom_expected[$];

	function automatic longint round_down(longint v, int sh);
		return (sh == 0) ? v : v + (64'sd1 <<< (sh - 1)) >>> sh;
	endfunction

	function automatic longint clip24(longint v);
		return v > 64'sd8388607 ? 64'sd8388607 : (v < -64'sd8388608 ? -64'sd8388608 : v);
	endfunction

	// Rotates a unit vector by the remainder angle, then maps it to the quadrant.
	task automatic heading_sin_cos(input logic [15:0] yaw, output longint s, output longint c);
		longint x, y, z, dx, dy, cx, sy;
		x = ROT_X0;
		y = 0;
		z = longint'(yaw[13:0]) <<< 16;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ANGLE_STEP[i];
			end else begin
				x += dx; y -= dy; z += ANGLE_STEP[i];
			end
		end
		case (yaw[15:14])
			2'd0: begin cx = x; sy = y; end
			2'd1: begin cx = -y; sy = x; end
			2'd2: begin cx = -x; sy = -y; end
			default: begin cx = y; sy = -x; end
		endcase
		c = round_down(cx, 30 - SINE_W);
		s = round_down(sy, 30 - SINE_W);
	endtask

	function automatic longint trapezoid_step(longint acc, longint vsum, longint unsigned dt);
		longint unsigned m;
		longint inc, sum;
		m = vsum < 0 ? -vsum : vsum;
		if (m != 0 && dt > longint'(INC_CAP) / m)
			inc = vsum < 0 ? -INC_CAP : INC_CAP;
		else
			inc = vsum < 0 ? -longint'(m * dt) : longint'(m * dt);
		sum = acc + inc;
		return sum > ACC_HI ? ACC_HI : (sum < ACC_LO ? ACC_LO : sum);
	endfunction

	function automatic logic [39:0] micrometres(longint acc);
		longint mag;
		mag = acc < 0 ? -acc : acc;
		mag = (mag + 64'sd1000000) / 64'sd2000000;
		return 40'(acc < 0 ? -mag : mag);
	endfunction

	task automatic predict_odometry(input sample_t smp);
		longint sx, sy, vx, vy, s, c, wx, wy;
		longint unsigned dt;
		result_t r;
		sx = longint'(smp.wheel_speed_1) + smp.wheel_speed_2 + smp.wheel_speed_3
			+ smp.wheel_speed_4;
		sy = longint'(smp.wheel_speed_1) + smp.wheel_speed_3 - smp.wheel_speed_2
			- smp.wheel_speed_4;
		vx = clip24(round_down(longint'(gx) * sx * longint'(radius), 24));
		vy = clip24(round_down(longint'(gy) * sy * longint'(radius), 24));
		heading_sin_cos(smp.yaw_angle, s, c);
		wx = clip24(round_down(vx * c - vy * s, SINE_W));
		wy = clip24(round_down(vx * s + vy * c, SINE_W));
		if (!started) begin
			dt = 0;
			prev_wx = wx;
			prev_wy = wy;
			started = 1;
		end else begin
			dt = longint'(32'(smp.stamp_us - prev_stamp));
		end
		dist_x = trapezoid_step(dist_x, wx + prev_wx, dt);
		dist_y = trapezoid_step(dist_y, wy + prev_wy, dt);
		prev_stamp = smp.stamp_us;
		prev_wx = wx;
		prev_wy = wy;
		r.position_x = micrometres(dist_x);
		r.position_y = micrometres(dist_y);
		r.body_vel_x = vx[23:0];
		r.body_vel_y = vy[23:0];
		odom_expected.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			gx = GAIN_RST;
			gy = GAIN_RST;
			radius = RADIUS_RST;
			started = 0;
			prev_stamp = 0;
			prev_wx = 0;
			prev_wy = 0;
			dist_x = 0;
			dist_y = 0;
			odom_expected.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN_X: gx = cfg_data[15:0];
					CFG_GAIN_Y: gy = cfg_data[15:0];
					CFG_RADIUS: radius = cfg_data[19:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (odom_expected.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result item: %p", result);
				end else begin
					want = odom_expected.pop_front();
					if (want !== result) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p, got %p", want, result);
					end
				end
			end
			if (push && !full)
				predict_odometry(sample);
		end
		pending = odom_expected.size();
	end
endmodule

/* test/mecanum_odometry_integrator_tb.sv */
// Top of the odometry integrator testbench: clock, reset, sample and register
// stimulus under several idle patterns, and the verdict from the checker.
// Depends on moi_pkg, the block and mecanum_odometry_integrator_checker.
`timescale 1ns / 100ps
module mecanum_odometry_integrator_tb;
	import moi_pkg::*;

	logic clk = 0, arst_n = 0, push = 0, pop = 0, cfg_valid = 0;
	logic full, empty, cfg_ready;
	sample_t sample = '0;
	result_t result;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int errors, pending, gap_pct = 0, stall_pct = 0, cycles = 0;
	logic [31:0] stamp_now = 0;

	always #5 clk = ~clk;

	mecanum_odometry_integrator DUT (.*);
	mecanum_odometry_integrator_checker checker_i (.*);

	always @(posedge clk) begin
		pop <= $urandom_range(99) >= stall_pct;
		cycles++;
		if (cycles > 1000000) begin
			$display("mecanum_odometry_integrator test failed");
			$finish;
		end
	end

	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < gap_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		sample <= s;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] wheel_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(512)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly steady forward time steps, with occasional jumps and steps backwards.
	function automatic sample_t random_sample();
		sample_t s;
		s.wheel_speed_1 = wheel_value();
		s.wheel_speed_2 = wheel_value();
		s.wheel_speed_3 = wheel_value();
		s.wheel_speed_4 = wheel_value();
		s.yaw_angle = 16'($urandom);
		case ($urandom_range(19))
			0: stamp_now = $urandom;
			1: stamp_now = stamp_now - $urandom_range(100000);
			default: stamp_now = stamp_now + $urandom_range(20000);
		endcase
		s.stamp_us = stamp_now;
		return s;
	endfunction

	function automatic sample_t fixed_sample(input logic [15:0] w, input logic [15:0] yaw,
			input logic [31:0] st);
		sample_t s;
		s.wheel_speed_1 = w;
		s.wheel_speed_2 = w;
		s.wheel_speed_3 = w;
		s.wheel_speed_4 = w;
		s.yaw_angle = yaw;
		s.stamp_us = st;
		return s;
	endfunction

	initial begin
		sample_t s;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: the first sample, quadrant corners, extremes, a backwards stamp.
		send_sample(fixed_sample(16'h7FFF, 16'h0000, 32'd1000));
		send_sample(fixed_sample(16'h7FFF, 16'h4000, 32'd2000));
		send_sample(fixed_sample(16'h8000, 16'h8000, 32'd3000));
		send_sample(fixed_sample(16'h8000, 16'hC000, 32'd4000));
		send_sample(fixed_sample(16'h0000, 16'hFFFF, 32'd5000));
		s = fixed_sample(16'h7FFF, 16'h2000, 32'd6000);
		s.wheel_speed_2 = 16'h8000;
		s.wheel_speed_4 = 16'h8000;
		send_sample(s);
		s.stamp_us = 32'hFFFF_FFFF;
		send_sample(s);
		s.stamp_us = 32'd10;
		send_sample(s);
		send_sample(fixed_sample(16'h7FFF, 16'h1234, 32'd5));
		send_sample(fixed_sample(16'h8000, 16'h9876, 32'd0));
		send_sample(fixed_sample(16'h8000, 16'h0001, 32'hFFFF_0000));
		drain();
		write_reg(CFG_GAIN_X, 0);
		write_reg(CFG_GAIN_Y, 0);
		write_reg(8'd3, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++)
			send_sample(random_sample());

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin write_reg(CFG_GAIN_X, 65535); write_reg(CFG_GAIN_Y, 65535);
					write_reg(CFG_RADIUS, 1048575); end
				1: begin write_reg(CFG_GAIN_X, 16384); write_reg(CFG_GAIN_Y, 0);
					write_reg(CFG_RADIUS, 1); end
				2: begin write_reg(CFG_GAIN_X, $urandom_range(65535));
					write_reg(CFG_GAIN_Y, $urandom_range(65535));
					write_reg(CFG_RADIUS, $urandom_range(1048575, 1)); end
				default: begin write_reg(CFG_GAIN_X, 16384); write_reg(CFG_GAIN_Y, 16384);
					write_reg(CFG_RADIUS, 45000); end
			endcase
			case (ph / 2)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 50; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 50; end
				default: begin gap_pct = 12; stall_pct = 12; end
			endcase
			for (int i = 0; i < 160; i++) begin
				if (ph == 2 && i == 80) begin
					push <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_sample(random_sample());
			end
		end

		push <= 0;
		stall_pct = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("mecanum_odometry_integrator test passed");
		else
			$display("mecanum_odometry_integrator test failed");
		$finish;
	end
endmodule
